@@ rtl/sgs_pkg.sv @@
// Package for the stepper gate sequencer: operation, status and outcome codes,
// register indexes, the half-step coil table and the motion mode type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sgs_pkg;

	// field widths
	localparam int OP_W        = 3;
	localparam int STATUS_W    = 3;
	localparam int OUTCOME_W   = 2;
	localparam int COIL_W      = 4;
	localparam int GATE_STEP_W = 16;
	localparam int CHUNK_W     = 10;
	localparam int PHASE_W     = 3;
	localparam int PHASE_COUNT = 8;

	// defaults
	localparam int STEP_COUNT_WIDTH_DEF = 16;
	localparam logic [GATE_STEP_W-1:0] GATE_STEPS_RST  = 16'd1024;
	localparam logic [CHUNK_W-1:0]     CHECK_CHUNK_RST = 10'd64;

	// configuration port
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic REG_GATE_STEPS  = 1'b0;
	localparam logic REG_CHECK_CHUNK = 1'b1;

	// operation codes
	localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
	localparam logic [OP_W-1:0] OP_OPEN    = 3'd1;
	localparam logic [OP_W-1:0] OP_CLOSE   = 3'd2;
	localparam logic [OP_W-1:0] OP_CHECKED = 3'd3;
	localparam logic [OP_W-1:0] OP_HOME    = 3'd4;

	// gate status codes
	localparam logic [STATUS_W-1:0] ST_CLOSED    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_OPEN      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_OPENING   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_CLOSING   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_REVERSING = 3'd4;

	// close outcome codes
	localparam logic [OUTCOME_W-1:0] OUT_NONE    = 2'd0;
	localparam logic [OUTCOME_W-1:0] OUT_DONE    = 2'd1;
	localparam logic [OUTCOME_W-1:0] OUT_ABORTED = 2'd2;

	// motion mode, one-hot
	typedef enum logic [5:0] {
		MODE_IDLE      = 6'b000001,
		MODE_OPENING   = 6'b000010,
		MODE_CLOSING   = 6'b000100,
		MODE_CHECKED   = 6'b001000,
		MODE_REVERSING = 6'b010000,
		MODE_HOMING    = 6'b100000
	} mode_t;

	// half-step coil pattern for each phase
	function automatic logic [COIL_W-1:0] half_step_drive(input logic [PHASE_W-1:0] ph);
		logic [COIL_W-1:0] d;
		case (ph)
			3'd0:    d = 4'h1;
			3'd1:    d = 4'h3;
			3'd2:    d = 4'h2;
			3'd3:    d = 4'h6;
			3'd4:    d = 4'h4;
			3'd5:    d = 4'hC;
			3'd6:    d = 4'h8;
			3'd7:    d = 4'h9;
			default: d = 4'h0;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

@@ rtl/stepper_gate_sequencer_top.sv @@
// Top level of the stepper gate sequencer: input register, state update,
// result register and APB configuration registers. Depends on sgs_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Stepper gate sequencer. Each input beat (a tick or a command) produces exactly
// one result beat that shows the coil drive, gate status, busy flag and last
// close outcome after the update. A beat is captured in an input register and
// is applied to the motion state once the result register can take it; one
// beat per cycle is sustained when the output side does not stall. The state
// update is a single step of the phase, step and chunk counters per beat.
// gate_steps is latched when a motion starts; check_chunk is read at each step.
// Registers: gate_steps at byte address 0, check_chunk at byte address 4.
module stepper_gate_sequencer_top #(
	parameter int STEP_COUNT_WIDTH = sgs_pkg::STEP_COUNT_WIDTH_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// input channel
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire  [sgs_pkg::OP_W-1:0]            operation,
	input  wire                                 obstacle,
	// result channel
	output logic                                out_valid,
	input  wire                                 out_ready,
	output logic [sgs_pkg::COIL_W-1:0]          coils,
	output logic [sgs_pkg::STATUS_W-1:0]        gate_status,
	output logic                                busy_res,
	output logic [sgs_pkg::OUTCOME_W-1:0]       close_outcome,
	// configuration
	input  wire                                 psel,
	input  wire                                 penable,
	input  wire                                 pwrite,
	input  wire  [sgs_pkg::CFG_ADDR_W-1:0]      paddr,
	input  wire  [sgs_pkg::CFG_DATA_W-1:0]      pwdata,
	output logic [sgs_pkg::CFG_DATA_W-1:0]      prdata,
	output logic                                pready
);

	localparam int SW = STEP_COUNT_WIDTH;

	// configuration registers
	logic [sgs_pkg::GATE_STEP_W-1:0] gate_steps_q;
	logic [sgs_pkg::CHUNK_W-1:0]     check_chunk_q;
	logic                            cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_steps_q  <= sgs_pkg::GATE_STEPS_RST;
			check_chunk_q <= sgs_pkg::CHECK_CHUNK_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				sgs_pkg::REG_GATE_STEPS:  gate_steps_q  <= pwdata[sgs_pkg::GATE_STEP_W-1:0];
				sgs_pkg::REG_CHECK_CHUNK: check_chunk_q <= pwdata[sgs_pkg::CHUNK_W-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (paddr[2])
			sgs_pkg::REG_GATE_STEPS:
				prdata = {{(sgs_pkg::CFG_DATA_W-sgs_pkg::GATE_STEP_W){1'b0}}, gate_steps_q};
			sgs_pkg::REG_CHECK_CHUNK:
				prdata = {{(sgs_pkg::CFG_DATA_W-sgs_pkg::CHUNK_W){1'b0}}, check_chunk_q};
			default:
				prdata = '0;
		endcase
	end

	// input register
	logic                     valid_s1;
	logic [sgs_pkg::OP_W-1:0] op_s1;
	logic                     obstacle_s1;
	logic                     adv_s1;

	assign adv_s1   = valid_s1 & (~out_valid | out_ready);
	assign in_ready = ~valid_s1 | adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1       <= operation;
			obstacle_s1 <= obstacle;
		end
	end

	// motion state
	logic [sgs_pkg::PHASE_W-1:0]   phase_q,  phase_n;
	sgs_pkg::mode_t                mode_q,   mode_n;
	logic                          open_q,   open_n;
	logic [SW-1:0]                 done_q,   done_n;
	logic [SW-1:0]                 target_q, target_n;
	logic [sgs_pkg::CHUNK_W-1:0]   chunk_q,  chunk_n;
	logic [sgs_pkg::COIL_W-1:0]    coil_q,   coil_n;
	logic [sgs_pkg::OUTCOME_W-1:0] outcome_q, outcome_n;
	logic [sgs_pkg::STATUS_W-1:0]  status_n;
	logic                          fwd;
	logic                          start;
	sgs_pkg::mode_t                start_mode;

	// command decode while idle
	always_comb begin
		start      = 1'b0;
		start_mode = sgs_pkg::MODE_IDLE;
		case (op_s1)
			sgs_pkg::OP_OPEN: begin
				start      = ~open_q;
				start_mode = sgs_pkg::MODE_OPENING;
			end
			sgs_pkg::OP_CLOSE: begin
				start      = open_q;
				start_mode = sgs_pkg::MODE_CLOSING;
			end
			sgs_pkg::OP_CHECKED: begin
				start      = open_q;
				start_mode = sgs_pkg::MODE_CHECKED;
			end
			sgs_pkg::OP_HOME: begin
				start      = 1'b1;
				start_mode = sgs_pkg::MODE_HOMING;
			end
			default: ;
		endcase
	end

	assign fwd = (mode_q == sgs_pkg::MODE_OPENING) || (mode_q == sgs_pkg::MODE_REVERSING);

	// next state for one beat
	always_comb begin
		phase_n   = phase_q;
		mode_n    = mode_q;
		open_n    = open_q;
		done_n    = done_q;
		target_n  = target_q;
		chunk_n   = chunk_q;
		coil_n    = coil_q;
		outcome_n = outcome_q;
		if (op_s1 == sgs_pkg::OP_TICK) begin
			if (mode_q != sgs_pkg::MODE_IDLE) begin
				if (done_q >= target_q) begin
					// motion complete: de-energize and record the position
					coil_n = '0;
					mode_n = sgs_pkg::MODE_IDLE;
					case (mode_q)
						sgs_pkg::MODE_OPENING:   open_n = 1'b1;
						sgs_pkg::MODE_CHECKED: begin
							open_n    = 1'b0;
							outcome_n = sgs_pkg::OUT_DONE;
						end
						sgs_pkg::MODE_REVERSING: outcome_n = sgs_pkg::OUT_ABORTED;
						default:                 open_n = 1'b0;
					endcase
				end else begin
					phase_n = fwd ? phase_q + 1'b1 : phase_q - 1'b1;
					coil_n  = sgs_pkg::half_step_drive(phase_n);
					done_n  = done_q + 1'b1;
					if (mode_q == sgs_pkg::MODE_CHECKED) begin
						chunk_n = chunk_q + 1'b1;
						// chunk boundary: obstacle check
						if (chunk_n == check_chunk_q) begin
							chunk_n = '0;
							if (done_n < target_q && obstacle_s1) begin
								target_n = done_n;
								done_n   = '0;
								mode_n   = sgs_pkg::MODE_REVERSING;
							end
						end
					end
				end
			end
		end else if (mode_q == sgs_pkg::MODE_IDLE && start) begin
			mode_n    = start_mode;
			done_n    = '0;
			target_n  = SW'(gate_steps_q);
			chunk_n   = '0;
			outcome_n = sgs_pkg::OUT_NONE;
		end
	end

	// status seen after the update
	always_comb begin
		case (mode_n)
			sgs_pkg::MODE_IDLE:      status_n = open_n ? sgs_pkg::ST_OPEN : sgs_pkg::ST_CLOSED;
			sgs_pkg::MODE_OPENING:   status_n = sgs_pkg::ST_OPENING;
			sgs_pkg::MODE_REVERSING: status_n = sgs_pkg::ST_REVERSING;
			default:                 status_n = sgs_pkg::ST_CLOSING;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= '0;
			mode_q    <= sgs_pkg::MODE_IDLE;
			open_q    <= 1'b0;
			done_q    <= '0;
			target_q  <= '0;
			chunk_q   <= '0;
			coil_q    <= '0;
			outcome_q <= sgs_pkg::OUT_NONE;
		end else if (adv_s1) begin
			phase_q   <= phase_n;
			mode_q    <= mode_n;
			open_q    <= open_n;
			done_q    <= done_n;
			target_q  <= target_n;
			chunk_q   <= chunk_n;
			coil_q    <= coil_n;
			outcome_q <= outcome_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv_s1) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			coils         <= coil_n;
			gate_status   <= status_n;
			busy_res      <= (mode_n != sgs_pkg::MODE_IDLE);
			close_outcome <= outcome_n;
		end
	end

	// coils are off whenever no motion is running
	a_idle_coils_off: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == sgs_pkg::MODE_IDLE) |-> (coil_q == '0))
		else $error("coils driven while idle");

	// step count never passes its target during a motion
	a_steps_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q != sgs_pkg::MODE_IDLE) |-> (done_q <= target_q))
		else $error("step count beyond target");

	// a command taken during a motion leaves the motion unchanged
	a_cmd_ignored_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && op_s1 != sgs_pkg::OP_TICK && mode_q != sgs_pkg::MODE_IDLE)
		|=> (mode_q == $past(mode_q) && done_q == $past(done_q)))
		else $error("command altered a running motion");

endmodule

`default_nettype wire
